>>> src/haversine_great_circle_distance_macros.svh
// Assertion macros shared by the distance block.
`ifndef HAVERSINE_GREAT_CIRCLE_DISTANCE_MACROS_SVH
`define HAVERSINE_GREAT_CIRCLE_DISTANCE_MACROS_SVH

// Asserts that a condition implies a consequent in the same cycle.
`define HGCD_ASSERT_IMP(label, ck, rs, cond, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (cond) |-> (cons)) else $error(msg);

// Asserts that a condition implies a consequent in the next cycle.
`define HGCD_ASSERT_NEXT(label, ck, rs, cond, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (cond) |=> (cons)) else $error(msg);

`endif

>>> src/hgcd_pkg.sv
`timescale 1ns / 1ps
package hgcd_pkg;

  localparam int CORDIC_STEPS = 28;
  localparam int W = 36;
  localparam logic signed [W-1:0] QONE = 36'sd1073741824;
  localparam logic signed [W-1:0] GAIN_INV = 36'sd652032874;
  localparam logic [33:0] HU90 = 34'd1800000000;
  localparam logic [33:0] HU180 = 34'd3600000000;
  localparam logic [34:0] HU360 = 35'd7200000000;
  localparam logic [31:0] RAD_PER_HU = 32'd4024455254;
  localparam logic [22:0] RADIUS_RESET = 23'd6378137;
  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  typedef logic signed [W-1:0] q_t;

  typedef struct packed {
    logic signed [34:0] d_lat;
    logic signed [34:0] d_lon;
    logic signed [34:0] lat_a2;
    logic signed [34:0] lat_b2;
  } angles_t;

  function automatic q_t atan_entry(input int i);
    q_t r;
    unique case (i)
      0: r = 36'sd843314857;   1: r = 36'sd497837829;
      2: r = 36'sd263043837;   3: r = 36'sd133525159;
      4: r = 36'sd67021687;    5: r = 36'sd33543516;
      6: r = 36'sd16775851;    7: r = 36'sd8388437;
      8: r = 36'sd4194283;     9: r = 36'sd2097149;
      10: r = 36'sd1048576;    11: r = 36'sd524288;
      12: r = 36'sd262144;     13: r = 36'sd131072;
      14: r = 36'sd65536;      15: r = 36'sd32768;
      16: r = 36'sd16384;      17: r = 36'sd8192;
      18: r = 36'sd4096;       19: r = 36'sd2048;
      20: r = 36'sd1024;       21: r = 36'sd512;
      22: r = 36'sd256;        23: r = 36'sd128;
      24: r = 36'sd64;         25: r = 36'sd32;
      26: r = 36'sd16;         27: r = 36'sd8;
      28: r = 36'sd4;          29: r = 36'sd2;
      30: r = 36'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic q_t mulq(input q_t a, input q_t b);
    logic [W-1:0] ma;
    logic [W-1:0] mb;
    logic [2*W-1:0] p;
    q_t r;
    ma = a[W-1] ? W'(-a) : W'(a);
    mb = b[W-1] ? W'(-b) : W'(b);
    p = ma * mb + (72'd1 << 29);
    r = q_t'(p >> 30);
    return (a[W-1] != b[W-1]) ? -r : r;
  endfunction

endpackage

>>> src/hgcd_front.sv
`timescale 1ns / 1ps
module hgcd_front (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic stall,
  input  logic signed [30:0] lat_a,
  input  logic signed [31:0] lon_a,
  input  logic signed [30:0] lat_b,
  input  logic signed [31:0] lon_b,
  output logic q_valid,
  input  logic q_pop,
  output hgcd_pkg::angles_t q_data
);

  hgcd_pkg::angles_t mem [hgcd_pkg::QDEPTH];
  logic [hgcd_pkg::QAW-1:0] wp;
  logic [hgcd_pkg::QAW-1:0] rp;
  logic [hgcd_pkg::QAW:0] cnt;
  logic push;
  hgcd_pkg::angles_t item;

  assign stall = (cnt == 3'(hgcd_pkg::QDEPTH));
  assign push = valid && !stall;
  assign q_valid = (cnt != '0);
  assign q_data = mem[rp];

  always_comb begin
    item.d_lat = 35'(lat_b) - 35'(lat_a);
    item.d_lon = 35'(lon_b) - 35'(lon_a);
    item.lat_a2 = 35'(lat_a) <<< 1;
    item.lat_b2 = 35'(lat_b) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= item;
    end
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (q_pop) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + 3'(push) - 3'(q_pop);
    end
  end

endmodule

>>> src/hgcd_back.sv
`timescale 1ns / 1ps
`include "haversine_great_circle_distance_macros.svh"
module hgcd_back (
  input  logic clk,
  input  logic rst,
  input  logic [22:0] radius,
  input  logic q_valid,
  output logic q_pop,
  input  hgcd_pkg::angles_t q_data,
  output logic valid,
  input  logic stall,
  output logic [24:0] distance_m
);

  localparam int N = hgcd_pkg::CORDIC_STEPS;
  localparam int W = hgcd_pkg::W;
  localparam int L = 2 + N + 3 + 31 + N + 2;
  localparam logic signed [36:0] H90 = 37'(hgcd_pkg::HU90);
  localparam logic signed [36:0] H180 = 37'(hgcd_pkg::HU180);
  localparam logic signed [36:0] H360 = 37'(hgcd_pkg::HU360);

  // Whole pipeline advances when the output register is free.
  logic adv;
  logic [L-1:0] vs;
  assign adv = !valid || !stall;
  assign q_pop = adv && q_valid;

  // Differences and doubled latitudes stay within one turn, so a single
  // correction wraps them.
  function automatic logic signed [36:0] fold(input logic signed [34:0] u,
                                              output logic negc);
    logic signed [36:0] r;
    r = 37'(u);
    negc = 1'b0;
    if (r < 0) r = r + H360;
    if (r >= H180) r = r - H360;
    if (r > H90) begin
      r = H180 - r;
      negc = 1'b1;
    end else if (r < -H90) begin
      r = -H180 - r;
      negc = 1'b1;
    end
    return r;
  endfunction

  function automatic logic signed [W-1:0] to_rad(input logic signed [36:0] r);
    logic [33:0] mag;
    logic [65:0] p;
    logic signed [W-1:0] th;
    mag = r[36] ? 34'(-r) : 34'(r);
    p = mag * hgcd_pkg::RAD_PER_HU + (66'd1 << 31);
    th = W'(p >> 32);
    return r[36] ? -th : th;
  endfunction

  // Stage 0: fold the four angles, then convert them to radians.
  logic signed [36:0] fr [4];
  logic [3:0] fnc;
  logic signed [36:0] f0 [4];
  logic [3:0] fn0;
  logic signed [W-1:0] z0 [4];
  logic [3:0] nc0;
  always_comb begin
    fr[0] = fold(q_data.d_lat, fnc[0]);
    fr[1] = fold(q_data.d_lon, fnc[1]);
    fr[2] = fold(q_data.lat_a2, fnc[2]);
    fr[3] = fold(q_data.lat_b2, fnc[3]);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        f0[k] <= fr[k];
        z0[k] <= to_rad(f0[k]);
      end
      fn0 <= fnc;
      nc0 <= fn0;
    end
  end

  // Rotation stages.
  logic signed [W-1:0] rx [N+1][4];
  logic signed [W-1:0] ry [N+1][4];
  logic signed [W-1:0] rz [N+1][4];
  logic [3:0] rn [N+1];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rx[0][k] = hgcd_pkg::GAIN_INV;
      ry[0][k] = '0;
      rz[0][k] = z0[k];
    end
    rn[0] = nc0;
  end
  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (adv) begin
        rn[i+1] <= rn[i];
        for (int k = 0; k < 4; k++) begin
          if (!rz[i][k][W-1]) begin
            rx[i+1][k] <= rx[i][k] - (ry[i][k] >>> i);
            ry[i+1][k] <= ry[i][k] + (rx[i][k] >>> i);
            rz[i+1][k] <= rz[i][k] - hgcd_pkg::atan_entry(i);
          end else begin
            rx[i+1][k] <= rx[i][k] + (ry[i][k] >>> i);
            ry[i+1][k] <= ry[i][k] - (rx[i][k] >>> i);
            rz[i+1][k] <= rz[i][k] + hgcd_pkg::atan_entry(i);
          end
        end
      end
    end
  end

  // Products, then sum and clamp.
  logic signed [W-1:0] p1, pc, ps, ca, cb, s1, s2;
  logic signed [W-1:0] c1, c2, amid;
  logic [30:0] a_c;
  always_comb begin
    s1 = ry[N][0];
    s2 = ry[N][1];
    ca = rn[N][2] ? -rx[N][2] : rx[N][2];
    cb = rn[N][3] ? -rx[N][3] : rx[N][3];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p1 <= hgcd_pkg::mulq(s1, s1);
      pc <= hgcd_pkg::mulq(ca, cb);
      ps <= hgcd_pkg::mulq(s2, s2);
      c1 <= p1;
      c2 <= hgcd_pkg::mulq(pc, ps);
      amid <= c1 + c2;
    end
  end
  always_comb begin
    if (amid[W-1]) a_c = '0;
    else if (amid > hgcd_pkg::QONE) a_c = 31'(hgcd_pkg::QONE);
    else a_c = 31'(amid);
  end

  // Square roots of a and 1-a, one result bit per stage (31 stages).
  localparam int RB = 31;
  logic [61:0] rema [RB+1], remb [RB+1];
  logic [61:0] na [RB+1], nb [RB+1];
  logic [30:0] qa [RB+1], qb [RB+1];
  always_comb begin
    na[0] = 62'(a_c) << 30;
    nb[0] = 62'(31'(hgcd_pkg::QONE) - a_c) << 30;
    rema[0] = '0;
    remb[0] = '0;
    qa[0] = '0;
    qb[0] = '0;
  end
  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    logic [63:0] ta, tb;
    assign ta = {rema[j], na[j][61:60]} - {31'd0, qa[j], 2'b01};
    assign tb = {remb[j], nb[j][61:60]} - {31'd0, qb[j], 2'b01};
    always_ff @(posedge clk) begin
      if (adv) begin
        na[j+1] <= na[j] << 2;
        nb[j+1] <= nb[j] << 2;
        if (!ta[63]) begin
          rema[j+1] <= ta[61:0];
          qa[j+1] <= {qa[j][29:0], 1'b1};
        end else begin
          rema[j+1] <= {rema[j][59:0], na[j][61:60]};
          qa[j+1] <= {qa[j][29:0], 1'b0};
        end
        if (!tb[63]) begin
          remb[j+1] <= tb[61:0];
          qb[j+1] <= {qb[j][29:0], 1'b1};
        end else begin
          remb[j+1] <= {remb[j][59:0], nb[j][61:60]};
          qb[j+1] <= {qb[j][29:0], 1'b0};
        end
      end
    end
  end

  // Vectoring stages.
  logic signed [W-1:0] vx [N+1], vy [N+1], vz [N+1];
  always_comb begin
    vx[0] = W'(qb[RB]);
    vy[0] = W'(qa[RB]);
    vz[0] = '0;
  end
  for (genvar i = 0; i < N; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (adv) begin
        if (vy[i] > 0) begin
          vx[i+1] <= vx[i] + (vy[i] >>> i);
          vy[i+1] <= vy[i] - (vx[i] >>> i);
          vz[i+1] <= vz[i] + hgcd_pkg::atan_entry(i);
        end else begin
          vx[i+1] <= vx[i] - (vy[i] >>> i);
          vy[i+1] <= vy[i] + (vx[i] >>> i);
          vz[i+1] <= vz[i] - hgcd_pkg::atan_entry(i);
        end
      end
    end
  end

  // Scale by the radius.
  logic [W-1:0] cang;
  logic [22:0] rad_r;
  logic [W+22:0] prod;
  always_ff @(posedge clk) begin
    if (adv) begin
      cang <= vz[N][W-1] ? '0 : (vz[N] <<< 1);
      rad_r <= radius;
      prod <= cang * rad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      distance_m <= 25'(prod >> 30);
    end
    if (rst) begin
      vs <= '0;
      valid <= 1'b0;
    end else if (adv) begin
      vs <= {vs[L-2:0], q_valid};
      valid <= vs[L-1];
    end
  end

  `HGCD_ASSERT_IMP(a_pop_needs_room, clk, rst, q_pop, adv, "pop while output blocked")
  `HGCD_ASSERT_NEXT(a_hold_out, clk, rst, valid && stall, valid && $stable(distance_m),
    "result lost under stall")
  `HGCD_ASSERT_IMP(a_clamp, clk, rst, vs[N+4], a_c <= 31'(hgcd_pkg::QONE), "a out of range")

endmodule

>>> src/haversine_great_circle_distance.sv
`timescale 1ns / 1ps
// Channel  Handshake        Payload
// in       valid / stall    lat_a, lon_a, lat_b, lon_b
// out      out_valid/out_stall  distance_m
// cfg      cfg_we           cfg_data (earth radius, meters)
// One transaction per cycle sustained while out_stall is low; an accepted input
// transaction passes through the queue, two fold stages, two CORDIC chains, the
// 31-stage square root and the multiplier stages before out_valid rises.
// A four-entry queue absorbs input while the back pipeline is frozen, then stalls.
// Reset (rst, synchronous) empties the queue and pipeline and restores the radius.
// An output stall while out_valid is high freezes the whole back pipeline.
module haversine_great_circle_distance (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic stall,
  input  logic signed [30:0] lat_a,
  input  logic signed [31:0] lon_a,
  input  logic signed [30:0] lat_b,
  input  logic signed [31:0] lon_b,
  output logic out_valid,
  input  logic out_stall,
  output logic [24:0] distance_m,
  input  logic cfg_we,
  input  logic [22:0] cfg_data
);

  logic [22:0] earth_radius_m;
  logic q_valid;
  logic q_pop;
  hgcd_pkg::angles_t q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      earth_radius_m <= hgcd_pkg::RADIUS_RESET;
    end else if (cfg_we) begin
      earth_radius_m <= cfg_data;
    end
  end

  hgcd_front u_front (
    .clk(clk), .rst(rst), .valid(valid), .stall(stall),
    .lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  hgcd_back u_back (
    .clk(clk), .rst(rst), .radius(earth_radius_m),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .valid(out_valid), .stall(out_stall), .distance_m(distance_m)
  );

endmodule

>>> verif/haversine_great_circle_distance_checker.sv
`timescale 1ns / 1ps
module haversine_great_circle_distance_checker (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  input  logic stall,
  input  logic signed [30:0] lat_a,
  input  logic signed [31:0] lon_a,
  input  logic signed [30:0] lat_b,
  input  logic signed [31:0] lon_b,
  input  logic out_valid,
  input  logic out_stall,
  input  logic [24:0] distance_m,
  input  logic cfg_we,
  input  logic [22:0] cfg_data,
  output int fail_count,
  output int pending
);

  typedef longint unsigned u64_t;

  localparam longint HALF_90 = 64'sd1800000000;
  localparam longint HALF_180 = 64'sd3600000000;
  localparam longint HALF_360 = 64'sd7200000000;
  localparam longint unsigned RAD_SCALE = 64'd4024455254;
  localparam longint UNITY = 64'sd1073741824;

  longint arctan_tab [hgcd_pkg::CORDIC_STEPS];
  logic [22:0] radius;
  logic [24:0] distance_q [$];

  initial begin
    longint unsigned p;
    longint sum;
    longint term;
    longint unsigned k;
    arctan_tab[0] = 64'sd843314857;
    for (int i = 1; i < hgcd_pkg::CORDIC_STEPS; i++) begin
      p = 64'd1 << (62 - i);
      sum = 0;
      k = 0;
      while (p != 0) begin
        term = longint'(p / (2 * k + 1));
        sum += k[0] ? -term : term;
        if (2 * i >= 62) break;
        p = p >> (2 * i);
        k++;
      end
      arctan_tab[i] = longint'((u64_t'(sum) + (64'd1 << 31)) >> 32);
    end
    fail_count = 0;
  end

  function automatic longint frac_mul(longint a, longint b);
    longint unsigned ma;
    longint unsigned mb;
    longint r;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    r = longint'((ma * mb + (64'd1 << 29)) >> 30);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  task automatic rotate(input longint u, output longint s, output longint c);
    longint r;
    longint th;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint unsigned mag;
    bit negc;
    r = u % HALF_360;
    negc = 0;
    x = 64'sd652032874;
    y = 0;
    if (r < 0) r += HALF_360;
    if (r >= HALF_180) r -= HALF_360;
    if (r > HALF_90) begin
      r = HALF_180 - r;
      negc = 1;
    end else if (r < -HALF_90) begin
      r = -HALF_180 - r;
      negc = 1;
    end
    mag = r < 0 ? -r : r;
    th = longint'((mag * RAD_SCALE + (64'd1 << 31)) >> 32);
    z = r < 0 ? -th : th;
    for (int i = 0; i < hgcd_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_tab[i];
      end else begin
        x += dx; y -= dy; z += arctan_tab[i];
      end
    end
    s = y;
    c = negc ? -x : x;
  endtask

  function automatic longint vector_angle(longint y, longint x);
    longint z;
    longint dx;
    longint dy;
    z = 0;
    for (int i = 0; i < hgcd_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += arctan_tab[i];
      end else begin
        x -= dx; y += dy; z -= arctan_tab[i];
      end
    end
    return z < 0 ? 0 : z;
  endfunction

  task automatic predict_distance(input longint la, input longint oa, input longint lb,
                                  input longint ob, output logic [24:0] result);
    longint s1;
    longint s2;
    longint ca;
    longint cb;
    longint unused;
    longint a;
    longint c;
    longint unsigned sa;
    longint unsigned sb;
    longint unsigned d;
    rotate(lb - la, s1, unused);
    rotate(ob - oa, s2, unused);
    rotate(2 * la, unused, ca);
    rotate(2 * lb, unused, cb);
    a = frac_mul(s1, s1) + frac_mul(frac_mul(ca, cb), frac_mul(s2, s2));
    if (a < 0) a = 0;
    if (a > UNITY) a = UNITY;
    sa = int_sqrt(u64_t'(a) << 30);
    sb = int_sqrt(u64_t'(UNITY - a) << 30);
    c = 2 * vector_angle(longint'(sa), longint'(sb));
    d = (u64_t'(radius) * u64_t'(c)) >> 30;
    result = d[24:0];
  endtask

  task automatic report_mismatch(input string what, input logic [24:0] got,
                                 input logic [24:0] want);
    $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic [24:0] want;
    if (rst) begin
      radius <= hgcd_pkg::RADIUS_RESET;
      distance_q.delete();
    end else begin
      if (cfg_we) radius <= cfg_data;
      if (valid && !stall) begin
        predict_distance(longint'(lat_a), longint'(lon_a), longint'(lat_b),
                         longint'(lon_b), want);
        distance_q.insert(distance_q.size(), want);
      end
      if (out_valid && !out_stall) begin
        if (distance_q.size() == 0) begin
          report_mismatch("unexpected transaction, distance_m", distance_m, '0);
        end else begin
          want = distance_q.pop_front();
          if (distance_m !== want) report_mismatch("distance_m", distance_m, want);
        end
      end
    end
    pending = distance_q.size();
  end
endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
module tb;
  logic clk;
  logic rst;
  logic valid;
  logic stall;
  logic signed [30:0] lat_a;
  logic signed [31:0] lon_a;
  logic signed [30:0] lat_b;
  logic signed [31:0] lon_b;
  logic out_valid;
  logic out_stall;
  logic [24:0] distance_m;
  logic cfg_we;
  logic [22:0] cfg_data;
  int fail_count;
  int pending;
  int idle_cycles;
  int long_hold;
  int hold;
  bit quiet;

  haversine_great_circle_distance uut (
    .clk(clk), .rst(rst), .valid(valid), .stall(stall),
    .lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
    .out_valid(out_valid), .out_stall(out_stall), .distance_m(distance_m),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  haversine_great_circle_distance_checker checker_i (
    .clk(clk), .rst(rst), .valid(valid), .stall(stall),
    .lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
    .out_valid(out_valid), .out_stall(out_stall), .distance_m(distance_m),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst = 1; valid = 0; out_stall = 0; cfg_we = 0; cfg_data = '0;
    lat_a = '0; lon_a = '0; lat_b = '0; lon_b = '0;
    long_hold = 0; hold = 0; quiet = 0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 0;
  end

  always @(posedge clk) begin
    if (rst || (valid && !stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 5000) begin
      $display("haversine_great_circle_distance: mismatch");
      $finish;
    end
    if (!rst && out_valid && !out_stall) hold = quiet ? 0 : $urandom_range(0, 6);
  end

  always @(negedge clk) begin
    if (long_hold > 0) begin
      long_hold = long_hold - 1;
      out_stall <= 1;
    end else if (hold > 0) begin
      hold = hold - 1;
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  task automatic send_points(input longint la, input longint oa, input longint lb,
                             input longint ob);
    int gap;
    @(negedge clk);
    lat_a <= la[30:0];
    lat_b <= lb[30:0]; lon_b <= ob[31:0];
    lon_a <= oa[31:0];
    valid <= 1;
    do @(posedge clk); while (stall);
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      @(negedge clk) valid <= 0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain;
    @(negedge clk) valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_radius(input logic [22:0] r);
    drain();
    @(negedge clk);
    valid <= 0;
    cfg_we <= 1;
    cfg_data <= r;
    @(negedge clk) cfg_we <= 0;
  endtask

  function automatic longint rand_lat();
    return longint'($urandom_range(0, 1800000000)) - 900000000;
  endfunction

  function automatic longint rand_lon();
    return longint'($urandom_range(0, 3600000000)) - 1800000000;
  endfunction

  task automatic random_item;
    longint la;
    longint oa;
    int kind;
    kind = $urandom_range(0, 9);
    la = rand_lat();
    oa = rand_lon();
    if (kind < 6) begin
      send_points(la, oa, rand_lat(), rand_lon());
    end else if (kind < 8) begin
      send_points(la, oa, la + $urandom_range(0, 20000) - 10000,
                  oa + $urandom_range(0, 20000) - 10000);
    end else begin
      send_points(longint'($urandom()), longint'($urandom()),
                  longint'($urandom()), longint'($urandom()));
    end
  endtask

  initial begin
    logic [22:0] radii [4];
    radii = '{23'd1, 23'd8000000, 23'd0, 23'd8388607};
    @(negedge clk);
    while (rst) @(negedge clk);
    send_points(0, 0, 0, 0);
    send_points(900000000, 0, -900000000, 0);
    send_points(0, -1800000000, 0, 1800000000);
    send_points(0, 0, 0, 1800000000);
    send_points(0, 0, 0, -1800000000);
    send_points(450000000, 900000000, -450000000, -900000000);
    send_points(900000000, 1800000000, 900000000, -1800000000);
    send_points(-900000000, 1234567, -900000000, -7654321);
    send_points(123456789, 987654321, 123456789, 987654321);
    send_points(0, 1, 0, 0);
    send_points(1, 0, 0, 0);
    send_points(-1073741824, -2147483648, 1073741823, 2147483647);
    send_points(1073741823, 2147483647, -1073741824, -2147483648);
    send_points(-1, -1, -1, -1);
    send_points(899999999, 0, -899999999, 1799999999);
    send_points(0, 0, 0, 1799999999);
    for (int k = 0; k < 40; k++) begin
      if (k == 0) long_hold = 400;
      random_item();
    end
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      quiet = (ph == 2);
      if (ph > 0) set_radius(ph == 4 ? 23'd6378137 : radii[ph - 1]);
      for (int k = 0; k < (ph == 0 || ph == 4 ? 600 : 220); k++) random_item();
    end
    set_radius(radii[3]);
    for (int k = 0; k < 20; k++) random_item();
    @(negedge clk) valid <= 0;
    drain();
    if (fail_count == 0) begin
      $display("haversine_great_circle_distance: match");
    end else begin
      $display("haversine_great_circle_distance: mismatch");
    end
    $finish;
  end
endmodule
